// ===== sv/vec3_pkg.sv =====
// ----------------------------------------------------------------------------
// vec3_pkg
// shared widths, action codes and the records that travel down the cell rows
// ----------------------------------------------------------------------------
package vec3_pkg;

	localparam int WB  = 32;
	localparam int FB  = 16;
	localparam int NW  = 2 * WB;
	localparam int QB  = FB + 1;
	localparam int RW  = WB + FB + 1;
	localparam int SIW = $clog2(WB);
	localparam int QW  = $clog2(QB);
	localparam int LAT = WB + QB + 5;

	localparam logic [2:0] ACT_ADD   = 3'd0;
	localparam logic [2:0] ACT_NEG   = 3'd1;
	localparam logic [2:0] ACT_SCALE = 3'd2;
	localparam logic [2:0] ACT_LEN   = 3'd3;
	localparam logic [2:0] ACT_NORM  = 3'd4;
	localparam logic [2:0] ACT_CROSS = 3'd5;

	typedef struct packed {
		logic              vld;
		logic [2:0]        act;
		logic signed [WB-1:0] ax;
		logic signed [WB-1:0] ay;
		logic signed [WB-1:0] az;
		logic signed [WB-1:0] rx;
		logic signed [WB-1:0] ry;
		logic signed [WB-1:0] rz;
		logic              clip;
	} side_t;

	typedef struct packed {
		side_t         sd;
		logic [NW-1:0] n;
		logic [NW-1:0] res;
	} sq_t;

	typedef struct packed {
		side_t               sd;
		logic [WB-1:0]       len;
		logic [2:0][RW-1:0]  rem;
		logic [2:0][QB-1:0]  q;
	} dv_t;

endpackage

// ===== sv/vec3_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// vec3_sqrt_cell
// one result bit of the bitwise integer square root, registered
// ----------------------------------------------------------------------------
module vec3_sqrt_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [vec3_pkg::SIW-1:0]    idx,
	input  vec3_pkg::sq_t               d,
	output vec3_pkg::sq_t               q
);

	logic [vec3_pkg::SIW:0]    sh;
	logic [vec3_pkg::NW-1:0]   bitv;
	logic [vec3_pkg::NW:0]     tsum;
	logic                      ge;
	vec3_pkg::sq_t             nx;

	always_comb begin
		sh   = {vec3_pkg::SIW'(vec3_pkg::WB - 1) - idx, 1'b0};
		bitv = vec3_pkg::NW'(1) << sh;
		tsum = {1'b0, d.res} + {1'b0, bitv};
		ge   = {1'b0, d.n} >= tsum;
		nx   = d;
		if (ge) begin
			nx.n   = d.n - tsum[vec3_pkg::NW-1:0];
			nx.res = (d.res >> 1) + bitv;
		end else begin
			nx.res = d.res >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else begin
			q <= nx;
		end
	end

endmodule

// ===== sv/vec3_div_cell.sv =====
// ----------------------------------------------------------------------------
// vec3_div_cell
// one quotient bit of the restoring divide, three lanes, registered
// ----------------------------------------------------------------------------
module vec3_div_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [vec3_pkg::QW-1:0]   idx,
	input  vec3_pkg::dv_t             d,
	output vec3_pkg::dv_t             q
);

	logic [vec3_pkg::RW-1:0] dsh;
	vec3_pkg::dv_t           nx;

	always_comb begin
		dsh = vec3_pkg::RW'(d.len) << idx;
		nx  = d;
		for (int i = 0; i < 3; i++) begin
			if (d.rem[i] >= dsh) begin
				nx.rem[i] = d.rem[i] - dsh;
				nx.q[i]   = d.q[i] | (vec3_pkg::QB'(1) << idx);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else begin
			q <= nx;
		end
	end

endmodule

// ===== sv/vector3_alu_top.sv =====
// ----------------------------------------------------------------------------
// vector3_alu_top
// three-component Q16.16 vector unit: add, negate, scale, length,
// normalize and cross product with saturation
// ----------------------------------------------------------------------------
// usage:
//  a word is taken at each rising edge with start high and busy low; busy is
//  never raised, so a new word may enter every cycle
//  each word gives one result, shown for one cycle with done high once the word
//  has passed through every stage of the path below; results leave in order
//  the path is fixed length: three front stages (operand select, multiply,
//  combine and sum of squares), a row of 32 square root cells, one divide
//  setup stage, a row of 17 divide cells and the output register
//  rate is one word per cycle; latency is set by the two cell rows
//  the receiver cannot stall: a result must be taken in its done cycle
//  reset clears every valid flag in flight; results in flight are dropped
// ----------------------------------------------------------------------------
module vector3_alu_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [2:0]                     action,
	input  logic signed [vec3_pkg::WB-1:0] a_x,
	input  logic signed [vec3_pkg::WB-1:0] a_y,
	input  logic signed [vec3_pkg::WB-1:0] a_z,
	input  logic signed [vec3_pkg::WB-1:0] b_x,
	input  logic signed [vec3_pkg::WB-1:0] b_y,
	input  logic signed [vec3_pkg::WB-1:0] b_z,
	input  logic signed [vec3_pkg::WB-1:0] scale_factor,
	output logic                           done,
	output logic signed [vec3_pkg::WB-1:0] r_x,
	output logic signed [vec3_pkg::WB-1:0] r_y,
	output logic signed [vec3_pkg::WB-1:0] r_z,
	output logic [vec3_pkg::WB-2:0]        magnitude,
	output logic                           zero_length,
	output logic                           saturated
);

	localparam int WB = vec3_pkg::WB;
	localparam int FB = vec3_pkg::FB;
	localparam int XW = 2 * WB + 1;

	function automatic logic [WB:0] sat_w(input logic signed [XW-1:0] v);
		logic signed [XW-1:0] hi;
		logic signed [XW-1:0] lo;
		logic [WB:0]          r;
		hi = {{(WB+2){1'b0}}, {(WB-1){1'b1}}};
		lo = ~hi;
		if (v > hi) begin
			r = {1'b1, 1'b0, {(WB-1){1'b1}}};
		end else if (v < lo) begin
			r = {1'b1, 1'b1, {(WB-1){1'b0}}};
		end else begin
			r = {1'b0, v[WB-1:0]};
		end
		return r;
	endfunction

	function automatic logic signed [XW-1:0] sx(input logic signed [WB-1:0] v);
		return {{(WB+1){v[WB-1]}}, v};
	endfunction

	function automatic logic [WB-1:0] absv(input logic signed [WB-1:0] v);
		return v[WB-1] ? (~v + WB'(1)) : v;
	endfunction

	// input stage
	vec3_pkg::side_t       sd_in;
	logic signed [WB-1:0]  ma_in [3];
	logic signed [WB-1:0]  mb_in [3];
	logic signed [WB-1:0]  mc_in [3];
	logic signed [WB-1:0]  md_in [3];
	logic [WB:0]           sx_r;
	logic [WB:0]           sy_r;
	logic [WB:0]           sz_r;
	logic                  is_cross;
	logic                  is_scale;

	assign busy = 1'b0;

	always_comb begin
		is_cross = action == vec3_pkg::ACT_CROSS;
		is_scale = action == vec3_pkg::ACT_SCALE;
		sx_r = '0;
		sy_r = '0;
		sz_r = '0;
		if (action == vec3_pkg::ACT_ADD) begin
			sx_r = sat_w(sx(a_x) + sx(b_x));
			sy_r = sat_w(sx(a_y) + sx(b_y));
			sz_r = sat_w(sx(a_z) + sx(b_z));
		end else if (action == vec3_pkg::ACT_NEG) begin
			sx_r = sat_w(-sx(a_x));
			sy_r = sat_w(-sx(a_y));
			sz_r = sat_w(-sx(a_z));
		end
		sd_in.vld  = start & ~busy;
		sd_in.act  = action;
		sd_in.ax   = a_x;
		sd_in.ay   = a_y;
		sd_in.az   = a_z;
		sd_in.rx   = sx_r[WB-1:0];
		sd_in.ry   = sy_r[WB-1:0];
		sd_in.rz   = sz_r[WB-1:0];
		sd_in.clip = sx_r[WB] | sy_r[WB] | sz_r[WB];
		if (is_cross) begin
			ma_in[0] = a_y; mb_in[0] = b_z;
			ma_in[1] = a_z; mb_in[1] = b_x;
			ma_in[2] = a_x; mb_in[2] = b_y;
		end else if (is_scale) begin
			ma_in[0] = a_x; mb_in[0] = scale_factor;
			ma_in[1] = a_y; mb_in[1] = scale_factor;
			ma_in[2] = a_z; mb_in[2] = scale_factor;
		end else begin
			ma_in[0] = a_x; mb_in[0] = a_x;
			ma_in[1] = a_y; mb_in[1] = a_y;
			ma_in[2] = a_z; mb_in[2] = a_z;
		end
		mc_in[0] = a_z; md_in[0] = b_y;
		mc_in[1] = a_x; md_in[1] = b_z;
		mc_in[2] = a_y; md_in[2] = b_x;
	end

	vec3_pkg::side_t       sd_s1;
	logic signed [WB-1:0]  ma_s1 [3];
	logic signed [WB-1:0]  mb_s1 [3];
	logic signed [WB-1:0]  mc_s1 [3];
	logic signed [WB-1:0]  md_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sd_s1 <= '0;
		end else begin
			sd_s1 <= sd_in;
		end
	end

	always_ff @(posedge clk) begin
		ma_s1 <= ma_in;
		mb_s1 <= mb_in;
		mc_s1 <= mc_in;
		md_s1 <= md_in;
	end

	// multiply stage
	vec3_pkg::side_t         sd_s2;
	logic signed [2*WB-1:0]  pe_s2 [3];
	logic signed [2*WB-1:0]  po_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sd_s2 <= '0;
		end else begin
			sd_s2 <= sd_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pe_s2[i] <= ma_s1[i] * mb_s1[i];
			po_s2[i] <= mc_s1[i] * md_s1[i];
		end
	end

	// combine stage: round, saturate, sum of squares
	vec3_pkg::sq_t         sq_in;
	logic signed [XW-1:0]  dif [3];
	logic signed [XW-1:0]  rnd [3];
	logic [WB:0]           sv  [3];
	logic                  prod_act;

	always_comb begin
		prod_act = sd_s2.act == vec3_pkg::ACT_SCALE || sd_s2.act == vec3_pkg::ACT_CROSS;
		for (int i = 0; i < 3; i++) begin
			dif[i] = {pe_s2[i][2*WB-1], pe_s2[i]}
				- ((sd_s2.act == vec3_pkg::ACT_CROSS) ? {po_s2[i][2*WB-1], po_s2[i]} : XW'(0));
			rnd[i] = (dif[i] + (XW'(1) <<< (FB - 1))) >>> FB;
			sv[i]  = sat_w(rnd[i]);
		end
		sq_in.sd = sd_s2;
		if (prod_act) begin
			sq_in.sd.rx   = sv[0][WB-1:0];
			sq_in.sd.ry   = sv[1][WB-1:0];
			sq_in.sd.rz   = sv[2][WB-1:0];
			sq_in.sd.clip = sv[0][WB] | sv[1][WB] | sv[2][WB];
		end
		sq_in.n   = pe_s2[0] + pe_s2[1] + pe_s2[2];
		sq_in.res = '0;
	end

	vec3_pkg::sq_t sq [WB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq[0] <= '0;
		end else begin
			sq[0] <= sq_in;
		end
	end

	for (genvar k = 0; k < WB; k++) begin : g_sqrt
		vec3_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (vec3_pkg::SIW'(k)),
			.d      (sq[k]),
			.q      (sq[k+1])
		);
	end

	// divide setup
	vec3_pkg::dv_t   dv_in;
	logic [WB-1:0]   len_w;

	always_comb begin
		len_w     = sq[WB].res[WB-1:0];
		dv_in.sd  = sq[WB].sd;
		dv_in.len = len_w;
		dv_in.rem[0] = {1'b0, absv(sq[WB].sd.ax), {FB{1'b0}}} + vec3_pkg::RW'(len_w >> 1);
		dv_in.rem[1] = {1'b0, absv(sq[WB].sd.ay), {FB{1'b0}}} + vec3_pkg::RW'(len_w >> 1);
		dv_in.rem[2] = {1'b0, absv(sq[WB].sd.az), {FB{1'b0}}} + vec3_pkg::RW'(len_w >> 1);
		dv_in.q   = '0;
	end

	vec3_pkg::dv_t dv [vec3_pkg::QB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv[0] <= '0;
		end else begin
			dv[0] <= dv_in;
		end
	end

	for (genvar j = 0; j < vec3_pkg::QB; j++) begin : g_div
		vec3_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (vec3_pkg::QW'(FB - j)),
			.d      (dv[j]),
			.q      (dv[j+1])
		);
	end

	// output stage
	vec3_pkg::dv_t         fin;
	logic                  is_len;
	logic                  is_norm;
	logic                  len_zero;
	logic                  mclip;
	logic [WB-2:0]         magv;
	logic signed [WB-1:0]  qe [3];
	logic signed [WB-1:0]  nr [3];

	always_comb begin
		fin      = dv[vec3_pkg::QB];
		is_len   = fin.sd.act == vec3_pkg::ACT_LEN;
		is_norm  = fin.sd.act == vec3_pkg::ACT_NORM;
		len_zero = fin.len == '0;
		mclip    = fin.len[WB-1];
		magv     = mclip ? {(WB-1){1'b1}} : fin.len[WB-2:0];
		for (int i = 0; i < 3; i++) begin
			qe[i] = {{(WB-vec3_pkg::QB){1'b0}}, fin.q[i]};
		end
		nr[0] = fin.sd.ax[WB-1] ? -qe[0] : qe[0];
		nr[1] = fin.sd.ay[WB-1] ? -qe[1] : qe[1];
		nr[2] = fin.sd.az[WB-1] ? -qe[2] : qe[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= fin.sd.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (is_norm) begin
			r_x <= len_zero ? '0 : nr[0];
			r_y <= len_zero ? '0 : nr[1];
			r_z <= len_zero ? '0 : nr[2];
		end else begin
			r_x <= fin.sd.rx;
			r_y <= fin.sd.ry;
			r_z <= fin.sd.rz;
		end
		magnitude   <= (is_len || is_norm) ? magv : '0;
		zero_length <= is_norm & len_zero;
		saturated   <= fin.sd.clip | ((is_len || is_norm) & mclip);
	end

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(vec3_pkg::LAT) done)
		else $error("result strobe missing after fixed latency");

	a_zero_vec: assert property (@(posedge clk) disable iff (!arst_n)
		done && zero_length |-> magnitude == '0 && r_x == '0 && r_y == '0 && r_z == '0)
		else $error("zero vector normalize gave nonzero result");

	a_zero_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		done && zero_length |-> !saturated)
		else $error("zero vector normalize flagged saturation");
`endif

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives vector3_alu_top with directed and random words in phases with differing
// idle gaps, predicts every result and compares it field by field
// ----------------------------------------------------------------------------
module testbench;

	typedef struct {
		logic [2:0]                     act;
		logic signed [vec3_pkg::WB-1:0] ax, ay, az, bx, by, bz, sf;
	} vec_word_t;

	typedef struct {
		logic signed [vec3_pkg::WB-1:0] rx, ry, rz;
		logic [vec3_pkg::WB-2:0]        mag;
		logic                           zl, sat;
	} vec_result_t;

	class vec_scoreboard;
		vec_result_t pending[$];
		int errors;

		function automatic logic signed [vec3_pkg::WB-1:0] clip_word(
				input logic signed [65:0] v, inout bit c);
			if (v > 66'sd2147483647) begin
				c = 1;
				return 32'sh7fffffff;
			end
			if (v < -66'sd2147483648) begin
				c = 1;
				return 32'sh80000000;
			end
			return v[vec3_pkg::WB-1:0];
		endfunction

		function automatic longint unsigned int_sqrt(input longint unsigned n);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > n)
				b >>= 2;
			while (b != 0) begin
				if (n >= res + b) begin
					n -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function automatic logic signed [vec3_pkg::WB-1:0] norm_comp(
				input logic signed [65:0] a, input longint unsigned len, inout bit c);
			logic signed [65:0] num, q;
			logic [65:0] m;
			num = a * 66'sd65536;
			m = (num < 0) ? -num : num;
			q = (m + len / 2) / len;
			return clip_word((num < 0) ? -q : q, c);
		endfunction

		function automatic vec_result_t predict(input vec_word_t w);
			vec_result_t r;
			logic signed [65:0] ax, ay, az, bx, by, bz, s, half;
			longint unsigned len;
			bit c;
			ax = w.ax; ay = w.ay; az = w.az;
			bx = w.bx; by = w.by; bz = w.bz; s = w.sf;
			half = 66'sd32768;
			c = 0;
			r.rx = 0; r.ry = 0; r.rz = 0; r.mag = 0; r.zl = 0;
			case (w.act)
				vec3_pkg::ACT_ADD: begin
					r.rx = clip_word(ax + bx, c);
					r.ry = clip_word(ay + by, c);
					r.rz = clip_word(az + bz, c);
				end
				vec3_pkg::ACT_NEG: begin
					r.rx = clip_word(-ax, c);
					r.ry = clip_word(-ay, c);
					r.rz = clip_word(-az, c);
				end
				vec3_pkg::ACT_SCALE: begin
					r.rx = clip_word((ax * s + half) >>> vec3_pkg::FB, c);
					r.ry = clip_word((ay * s + half) >>> vec3_pkg::FB, c);
					r.rz = clip_word((az * s + half) >>> vec3_pkg::FB, c);
				end
				vec3_pkg::ACT_LEN, vec3_pkg::ACT_NORM: begin
					len = int_sqrt(64'(ax * ax + ay * ay + az * az));
					if (len > 64'd2147483647) begin
						r.mag = '1;
						c = 1;
					end else begin
						r.mag = len[vec3_pkg::WB-2:0];
					end
					if (w.act == vec3_pkg::ACT_NORM) begin
						if (len == 0) begin
							r.zl = 1;
						end else begin
							r.rx = norm_comp(ax, len, c);
							r.ry = norm_comp(ay, len, c);
							r.rz = norm_comp(az, len, c);
						end
					end
				end
				vec3_pkg::ACT_CROSS: begin
					r.rx = clip_word((ay * bz - az * by + half) >>> vec3_pkg::FB, c);
					r.ry = clip_word((az * bx - ax * bz + half) >>> vec3_pkg::FB, c);
					r.rz = clip_word((ax * by - ay * bx + half) >>> vec3_pkg::FB, c);
				end
				default: ;
			endcase
			r.sat = c;
			return r;
		endfunction

		function void note_word(input vec_word_t w);
			pending = {pending, predict(w)};
		endfunction

		function void check_result(input vec_result_t got);
			vec_result_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result rx=%h ry=%h rz=%h", got.rx, got.ry, got.rz);
				return;
			end
			e = pending.pop_front();
			if (got.rx !== e.rx || got.ry !== e.ry || got.rz !== e.rz
					|| got.mag !== e.mag || got.zl !== e.zl || got.sat !== e.sat) begin
				errors++;
				if (errors <= 10)
					$display("mismatch exp %h %h %h %h %b %b got %h %h %h %h %b %b",
						e.rx, e.ry, e.rz, e.mag, e.zl, e.sat,
						got.rx, got.ry, got.rz, got.mag, got.zl, got.sat);
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, done, zero_length, saturated;
	logic [2:0] action;
	logic signed [vec3_pkg::WB-1:0] a_x, a_y, a_z, b_x, b_y, b_z, scale_factor;
	logic signed [vec3_pkg::WB-1:0] r_x, r_y, r_z;
	logic [vec3_pkg::WB-2:0] magnitude;

	vec_scoreboard sb;

	vector3_alu_top i_dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	always @(posedge clk) begin
		vec_result_t got;
		if (arst_n && done) begin
			got.rx = r_x; got.ry = r_y; got.rz = r_z;
			got.mag = magnitude; got.zl = zero_length; got.sat = saturated;
			sb.check_result(got);
		end
	end

	task automatic send_word(input vec_word_t w);
		action <= w.act;
		a_x <= w.ax; a_y <= w.ay; a_z <= w.az;
		b_x <= w.bx; b_y <= w.by; b_z <= w.bz;
		scale_factor <= w.sf;
		start <= 1;
		do @(posedge clk); while (busy);
		sb.note_word(w);
	endtask

	task automatic idle_cycles(input int n);
		start <= 0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain;
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	function automatic logic signed [vec3_pkg::WB-1:0] rand_comp(input int kind);
		case (kind)
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
			2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000;
		endcase
	endfunction

	function automatic vec_word_t rand_word();
		vec_word_t w;
		int kind;
		kind = $urandom_range(0, 3);
		w.act = ($urandom_range(0, 39) == 0) ? 3'($urandom_range(6, 7))
			: 3'($urandom_range(0, 5));
		w.ax = rand_comp(kind); w.ay = rand_comp(kind); w.az = rand_comp(kind);
		w.bx = rand_comp(kind); w.by = rand_comp(kind); w.bz = rand_comp(kind);
		w.sf = rand_comp($urandom_range(0, 3));
		if ($urandom_range(0, 15) == 0) begin
			w.ax = 0; w.ay = 0; w.az = 0;
		end
		return w;
	endfunction

	initial begin
		vec_word_t w;
		int gap_pct;
		logic signed [vec3_pkg::WB-1:0] ext [4];
		ext = '{32'sh7fffffff, 32'sh80000000, 32'sh0, 32'sh10000};
		sb = new();
		arst_n = 0;
		start = 0;
		action = 0;
		a_x = 0; a_y = 0; a_z = 0; b_x = 0; b_y = 0; b_z = 0; scale_factor = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: every action on extreme components, zero vector, unused codes
		for (int a = 0; a < 8; a++) begin
			for (int k = 0; k < 3; k++) begin
				w.act = 3'(a);
				w.ax = ext[k]; w.ay = ext[(k + 1) % 4]; w.az = ext[(k + 3) % 4];
				w.bx = ext[(k + 2) % 4]; w.by = ext[k]; w.bz = ext[(k + 1) % 4];
				w.sf = ext[(k + 1) % 4];
				if (k == 2 && (a == vec3_pkg::ACT_NORM || a == vec3_pkg::ACT_LEN)) begin
					w.ax = 0; w.ay = 0; w.az = 0;
				end
				send_word(w);
			end
		end
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			gap_pct = (ph == 1) ? 81 : (ph == 3) ? 14 : 0;
			for (int i = 0; i < 260; i++) begin
				while ($urandom_range(0, 99) < gap_pct)
					idle_cycles(1);
				send_word(rand_word());
			end
			drain();
		end

		repeat (vec3_pkg::LAT + 10) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
